// ===== hdl/sipd_pkg.sv =====
`timescale 1ns / 1ps

package sipd_pkg;

    localparam int VALUE_W     = 32;
    localparam int MINW_W      = 6;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_COUNT = 10;
    localparam int DIGIT_W     = 4;
    localparam int BCD_W       = DIGIT_COUNT * DIGIT_W;
    localparam int IDX_W       = $clog2(DIGIT_COUNT);
    localparam int CONV_STEPS  = VALUE_W;
    localparam int STEP_W      = $clog2(CONV_STEPS);
    localparam int TEXT_W      = 4;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0]  CHAR_SPACE = 8'h20;
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_EMIT
    } sipd_state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic prep;
        logic emit;
    } sipd_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic last_char;
        logic out_free;
    } sipd_sts_t;

endpackage

// ===== hdl/sipd_in_if.sv =====
`timescale 1ns / 1ps

interface sipd_in_if;
    import sipd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;
    logic        [MINW_W-1:0]   min_width;

    modport source (output valid, output value, output min_width, input ready);
    modport sink   (input valid, input value, input min_width, output ready);
endinterface

// ===== hdl/sipd_out_if.sv =====
`timescale 1ns / 1ps

interface sipd_out_if;
    import sipd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

// ===== hdl/sipd_ctrl.sv =====
`timescale 1ns / 1ps

module sipd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sipd_pkg::sipd_sts_t sts,
    output sipd_pkg::sipd_cmd_t cmd
);
    import sipd_pkg::*;

    sipd_state_t state_reg;
    sipd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (sts.conv_last)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free && sts.last_char)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd.load  = 1'b0;
        cmd.shift = 1'b0;
        cmd.prep  = 1'b0;
        cmd.emit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/sipd_dpath.sv =====
`timescale 1ns / 1ps

module sipd_dpath #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [sipd_pkg::VALUE_W-1:0] value,
    input  logic [sipd_pkg::MINW_W-1:0]    min_width,
    input  sipd_pkg::sipd_cmd_t            cmd,
    output sipd_pkg::sipd_sts_t            sts,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [sipd_pkg::CHAR_W-1:0]    out_char,
    output logic                           out_last
);
    import sipd_pkg::*;

    localparam int PW = $clog2(MAX_WIDTH + 1);

    logic [VALUE_W-1:0] mag_reg;
    logic [VALUE_W-1:0] mag_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic               neg_reg;
    logic               neg_next;
    logic [PW-1:0]      width_reg;
    logic [PW-1:0]      width_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic [PW-1:0]      pad_reg;
    logic [PW-1:0]      pad_next;
    logic               sign_reg;
    logic               sign_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [CHAR_W-1:0]  char_reg;
    logic [CHAR_W-1:0]  char_next;
    logic               last_reg;
    logic               last_next;
    logic               valid_reg;
    logic               valid_next;

    logic [IDX_W-1:0]   top_idx;
    logic [TEXT_W-1:0]  text_len;
    logic [PW-1:0]      text_len_p;
    logic [DIGIT_W-1:0] cur_digit;

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int d = 0; d < DIGIT_COUNT; d++)
        begin
            if (bcd_reg[d*DIGIT_W +: DIGIT_W] >= DABBLE_MIN)
            begin
                bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
            end
            else
            begin
                bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb
    begin
        top_idx = '0;
        for (int d = 0; d < DIGIT_COUNT; d++)
        begin
            if (bcd_reg[d*DIGIT_W +: DIGIT_W] != '0)
            begin
                top_idx = IDX_W'(d);
            end
        end
    end

    assign text_len   = TEXT_W'(top_idx) + TEXT_W'(1) + TEXT_W'(neg_reg);
    assign text_len_p = PW'(text_len);
    assign cur_digit  = bcd_reg[idx_reg*DIGIT_W +: DIGIT_W];

    always_comb
    begin
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        width_next = width_reg;
        step_next  = step_reg;
        pad_next   = pad_reg;
        sign_next  = sign_reg;
        idx_next   = idx_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !out_ready;

        if (cmd.load)
        begin
            neg_next  = value[VALUE_W-1];
            mag_next  = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
            bcd_next  = '0;
            step_next = '0;
            if (int'(min_width) > MAX_WIDTH)
            begin
                width_next = PW'(MAX_WIDTH);
            end
            else
            begin
                width_next = PW'(min_width);
            end
        end

        if (cmd.shift)
        begin
            {bcd_next, mag_next} = {bcd_adj[BCD_W-2:0], mag_reg, 1'b0};
            step_next = step_reg + STEP_W'(1);
        end

        if (cmd.prep)
        begin
            idx_next  = top_idx;
            sign_next = neg_reg;
            if (width_reg > text_len_p)
            begin
                pad_next = width_reg - text_len_p;
            end
            else
            begin
                pad_next = '0;
            end
        end

        if (cmd.emit)
        begin
            valid_next = 1'b1;
            last_next  = 1'b0;
            if (pad_reg != '0)
            begin
                char_next = CHAR_SPACE;
                pad_next  = pad_reg - PW'(1);
            end
            else if (sign_reg)
            begin
                char_next = CHAR_MINUS;
                sign_next = 1'b0;
            end
            else
            begin
                char_next = CHAR_ZERO + CHAR_W'(cur_digit);
                last_next = (idx_reg == '0);
                if (idx_reg != '0)
                begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
            pad_reg   <= '0;
            sign_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
            pad_reg   <= pad_next;
            sign_reg  <= sign_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        bcd_reg   <= bcd_next;
        neg_reg   <= neg_next;
        width_reg <= width_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign sts.conv_last = (step_reg == STEP_W'(CONV_STEPS - 1));
    assign sts.last_char = (pad_reg == '0) && !sign_reg && (idx_reg == '0);
    assign sts.out_free  = !valid_reg || out_ready;

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

// ===== hdl/signed_int_to_padded_decimal.sv =====
`timescale 1ns / 1ps
// Flow: a request is accepted while idle, converted, and its field is sized before the first character on text.
// Conversion is 32 double-dabble shift steps, followed by the prep state that sizes the field.
// Each request emits 1 up to the larger of MAX_WIDTH and 11 characters; no new request is taken
// until its last character is emitted, since the request channel is ready only while idle.
// Reset: rst_n is asynchronous, active low; clears the controller and the output valid.

module signed_int_to_padded_decimal #(
    parameter int MAX_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    sipd_in_if.sink     number,
    sipd_out_if.source  text
);
    import sipd_pkg::*;

    sipd_cmd_t cmd;
    sipd_sts_t sts;
    logic      in_ready;

    sipd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (number.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sipd_dpath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (number.value),
        .min_width (number.min_width),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (text.ready),
        .out_valid (text.valid),
        .out_char  (text.out_char),
        .out_last  (text.last)
    );

    assign number.ready = in_ready;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sipd_pkg::*;

    localparam int FIELD_MAX   = 32;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int HOLD_AFTER  = 400;
    localparam int DRAIN_WAIT  = 40;
    localparam int RANDOM_REQS = 420;
    localparam int PRINT_LIMIT = 100;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic        [MINW_W-1:0]  min_width;
    } number_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    logic clk;
    logic rst_n;

    sipd_in_if  number_if ();
    sipd_out_if text_if ();

    signed_int_to_padded_decimal #(
        .MAX_WIDTH(FIELD_MAX)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .number(number_if),
        .text(text_if)
    );

    number_req_t pending_requests[$];
    text_char_t  expected_text[$];

    int  total_requests;
    int  requests_taken;
    int  chars_seen;
    int  error_count;
    int  cycle_count;
    int  gap_in;
    int  calm_in;
    int  stall_out;
    int  calm_out;
    int  hold_left;
    logic hold_done;
    logic in_taken;
    logic out_taken;

    always #5 clk = ~clk;

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic void add_request(input logic signed [VALUE_W-1:0] value,
                                        input logic [MINW_W-1:0] min_width);
        number_req_t req;
        req.value     = value;
        req.min_width = min_width;
        pending_requests.push_back(req);
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_value();
        int unsigned pick;
        int unsigned ndig;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned magnitude;
        logic [VALUE_W-1:0] mag_bits;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return $urandom;
        if (pick == 2)
        begin
            case ($urandom_range(0, 5))
                0: return 32'sh0000_0000;
                1: return 32'shFFFF_FFFF;
                2: return 32'sh0000_0001;
                3: return 32'sh7FFF_FFFF;
                4: return 32'sh8000_0000;
                default: return 32'sh8000_0001;
            endcase
        end
        ndig = $urandom_range(1, 10);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1)
            lo = 0;
        if (hi > 64'd2147483647)
            hi = 64'd2147483647;
        case ($urandom_range(0, 3))
            0: magnitude = lo;
            1: magnitude = hi;
            default: magnitude = $urandom_range(hi[31:0], lo[31:0]);
        endcase
        mag_bits = magnitude[31:0];
        if ($urandom_range(0, 1))
            return 32'd0 - mag_bits;
        return mag_bits;
    endfunction

    function automatic logic [MINW_W-1:0] random_width();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return MINW_W'($urandom_range(0, 12));
        if (r < 8)
            return MINW_W'($urandom_range(13, 32));
        return MINW_W'($urandom_range(33, 63));
    endfunction

    function automatic void predict_text(input logic signed [VALUE_W-1:0] value,
                                         input logic [MINW_W-1:0] min_width);
        logic [VALUE_W-1:0] magnitude;
        logic [DIGIT_W-1:0] digits [DIGIT_COUNT];
        logic               negative;
        int unsigned        ndig;
        int unsigned        width;
        int unsigned        text_len;
        int unsigned        pad;
        int unsigned        total;
        text_char_t         c;
        negative  = value[VALUE_W-1];
        magnitude = negative ? 32'd0 - value : value;
        ndig = 0;
        do
        begin
            digits[ndig] = DIGIT_W'(magnitude % 10);
            ndig++;
            magnitude = magnitude / 10;
        end
        while (magnitude != 0);
        width    = (min_width > FIELD_MAX) ? FIELD_MAX : min_width;
        text_len = ndig + (negative ? 1 : 0);
        pad      = (width > text_len) ? width - text_len : 0;
        total    = pad + text_len;
        for (int unsigned pos = 0; pos < total; pos++)
        begin
            if (pos < pad)
                c.ch = CHAR_SPACE;
            else if (negative && pos == pad)
                c.ch = CHAR_MINUS;
            else
                c.ch = CHAR_ZERO + digits[total - 1 - pos];
            c.last = (pos + 1 == total);
            expected_text.push_back(c);
        end
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    always @(negedge clk)
    begin
        number_req_t req;
        if (!rst_n)
            number_if.valid <= 1'b0;
        else if (!number_if.valid || in_taken)
        begin
            if (gap_in > 0)
            begin
                gap_in--;
                number_if.valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                req = pending_requests.pop_front();
                number_if.value     <= req.value;
                number_if.min_width <= req.min_width;
                number_if.valid     <= 1'b1;
                gap_in = pick_gap(calm_in);
            end
            else
                number_if.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            text_if.ready <= 1'b0;
        else
        begin
            if (!hold_done && chars_seen >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                text_if.ready <= 1'b0;
            end
            else
            begin
                if (out_taken)
                    stall_out = pick_gap(calm_out);
                if (stall_out > 0)
                begin
                    stall_out--;
                    text_if.ready <= 1'b0;
                end
                else
                    text_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        text_char_t want;
        in_taken  <= rst_n && number_if.valid && number_if.ready;
        out_taken <= rst_n && text_if.valid && text_if.ready;
        if (rst_n)
        begin
            if (number_if.valid && number_if.ready)
            begin
                predict_text(number_if.value, number_if.min_width);
                requests_taken++;
            end
            if (text_if.valid && text_if.ready)
            begin
                chars_seen++;
                if (expected_text.size() == 0)
                    report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                              text_if.out_char, text_if.last));
                else
                begin
                    want = expected_text.pop_front();
                    if (text_if.out_char !== want.ch)
                        report_mismatch($sformatf("char %0d: out_char 0x%02h, want 0x%02h",
                                                  chars_seen, text_if.out_char, want.ch));
                    if (text_if.last !== want.last)
                        report_mismatch($sformatf("char %0d: last %0b, want %0b",
                                                  chars_seen, text_if.last, want.last));
                end
            end
        end
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        number_if.valid = 1'b0;
        number_if.value = '0;
        number_if.min_width = '0;
        text_if.ready = 1'b0;
        total_requests = 0;
        requests_taken = 0;
        chars_seen = 0;
        error_count = 0;
        cycle_count = 0;
        gap_in = 0;
        calm_in = 0;
        stall_out = 0;
        calm_out = 0;
        hold_left = 0;
        hold_done = 1'b0;
        in_taken = 1'b0;
        out_taken = 1'b0;

        add_request(32'sd0, 6'd0);
        add_request(32'sd0, 6'd32);
        add_request(-32'sd1, 6'd0);
        add_request(32'sd1, 6'd1);
        add_request(32'sh8000_0000, 6'd0);
        add_request(32'sh8000_0000, 6'd11);
        add_request(32'sh8000_0000, 6'd32);
        add_request(32'sh7FFF_FFFF, 6'd0);
        add_request(32'sh7FFF_FFFF, 6'd10);
        add_request(32'sh7FFF_FFFF, 6'd63);
        add_request(32'sd12345, 6'd3);
        add_request(-32'sd12345, 6'd6);
        add_request(-32'sd12345, 6'd7);
        add_request(32'sd9, 6'd2);
        add_request(32'sd10, 6'd2);
        add_request(32'sd99, 6'd1);
        add_request(-32'sd9, 6'd2);
        add_request(32'sd100, 6'd33);
        add_request(-32'sd5, 6'd63);
        add_request(32'sd1000000000, 6'd10);
        add_request(32'sd999999999, 6'd9);
        add_request(-32'sd1000000000, 6'd40);
        add_request(32'sd42, 6'd31);
        repeat (RANDOM_REQS) add_request(random_value(), random_width());
        total_requests = pending_requests.size();

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        while (requests_taken < total_requests) @(posedge clk);
        while (expected_text.size() > 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
